@@ rtl/core/prime_factorizer_macros.svh @@
// Assertion macros shared by the prime factorizer RTL.
// Each macro checks on the rising edge of clk and is off while arst_n is low.
// Define NO_ASSERTIONS to compile every check away.
`ifndef PRIME_FACTORIZER_MACROS_SVH
`define PRIME_FACTORIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prime_factorizer: same-cycle check failed");

// Next-cycle implication.
`define PF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prime_factorizer: next-cycle check failed");

`else

`define PF_ASSERT_NOW(label, ante, cons)
`define PF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/pf_pkg.sv @@
package pf_pkg;

	// Default width of the value being factored.
	localparam int VALUE_BITS_DEF = 16;

	// Fixed field widths of the ports.
	localparam int NUMBER_W = 16;
	localparam int PRIME_W  = 16;
	localparam int EXP_W    = 5;

	// Which pair the output register takes.
	typedef logic [1:0] pf_emit_t;
	localparam pf_emit_t EMIT_NONE = 2'd0;
	localparam pf_emit_t EMIT_MID  = 2'd1;
	localparam pf_emit_t EMIT_LAST = 2'd2;
	localparam pf_emit_t EMIT_REST = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     div_start;
		logic     div_hit;
		logic     div_miss;
		pf_emit_t emit;
	} pf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic num_small;
		logic sq_gt;
		logic rest_gt1;
		logic div_done;
		logic rem_zero;
		logic exp_nz;
		logic pend_v;
	} pf_sts_t;

endpackage

@@ rtl/core/prime_factorizer.sv @@
// Each trial division is a bit-serial restoring division, and a repeated factor costs one
// more division; divisors run 2 and then the odd numbers from 3 up to the square root of what remains.
// At 16 bits a prime near 65535 needs 128 divisions before its one result.
// Throughput: one number at a time; results cannot be stalled and busy falls with the last.
// Reset clears the controller, the divider control, the pending flag and the strobe.
`include "prime_factorizer_macros.svh"

module prime_factorizer #(
	parameter int VALUE_BITS = pf_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [pf_pkg::NUMBER_W-1:0] number,
	output logic                        strobe,
	output logic [pf_pkg::PRIME_W-1:0]  prime,
	output logic [pf_pkg::EXP_W-1:0]    exponent,
	output logic                        last
);
	import pf_pkg::*;

	pf_cmd_t cmd;
	pf_sts_t sts;

	pf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	pf_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.number   (number),
		.cmd      (cmd),
		.sts      (sts),
		.strobe   (strobe),
		.prime    (prime),
		.exponent (exponent),
		.last     (last)
	);

	// A number of two or more keeps the block busy on the next cycle.
	`PF_ASSERT_NEXT(a_start_busy, start && !busy && !sts.num_small, busy)
	// Every result beat carries a prime of at least two and a nonzero exponent.
	`PF_ASSERT_NOW(a_pair_sane, strobe, exponent != '0 && prime >= PRIME_W'(2))
	// The final beat of a run is exactly the one seen as the block goes idle.
	`PF_ASSERT_NOW(a_last_idle, strobe, last == !busy)

endmodule

@@ rtl/core/pf_divider.sv @@
module pf_divider #(
	parameter int W  = pf_pkg::VALUE_BITS_DEF,
	parameter int DW = (pf_pkg::VALUE_BITS_DEF + 1) / 2 + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [W-1:0]  quotient,
	output logic [DW-1:0] remainder
);
	localparam int CW = $clog2(W + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [W-1:0]  quo_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic          fits;

	// One restoring step: bring down the next dividend bit and try to subtract.
	always_comb begin
		rem_sh  = {rem_q, quo_q[W-1]};
		rem_sub = rem_sh - {1'b0, divisor};
		fits    = rem_sh >= {1'b0, divisor};
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ rtl/core/pf_datapath.sv @@
module pf_datapath #(
	parameter int VALUE_BITS = pf_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pf_pkg::NUMBER_W-1:0]   number,
	input  pf_pkg::pf_cmd_t               cmd,
	output pf_pkg::pf_sts_t               sts,
	output logic                          strobe,
	output logic [pf_pkg::PRIME_W-1:0]    prime,
	output logic [pf_pkg::EXP_W-1:0]      exponent,
	output logic                          last
);
	import pf_pkg::*;

	localparam int W  = VALUE_BITS;
	// Trial divisors stay within a step of the square root.
	localparam int DW = (W + 1) / 2 + 1;
	localparam int SW = 2 * DW;

	logic [W-1:0]     num_w;
	logic [W-1:0]     rest_q;
	logic [DW-1:0]    d_q;
	logic [SW-1:0]    sq_q;
	logic [EXP_W-1:0] e_q;
	logic             pend_v_q;
	logic [DW-1:0]    pend_p_q;
	logic [EXP_W-1:0] pend_e_q;
	logic             strobe_q;
	logic [PRIME_W-1:0] prime_q;
	logic [EXP_W-1:0] exp_q;
	logic             last_q;
	logic             div_done;
	logic [W-1:0]     div_quo;
	logic [DW-1:0]    div_rem;

	// Only the low VALUE_BITS bits of the number take part.
	assign num_w = W'(number);

	pf_divider #(
		.W  (W),
		.DW (DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (rest_q),
		.divisor   (d_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Status toward the controller.
	always_comb begin
		sts.num_small = num_w < W'(2);
		sts.sq_gt     = sq_q > SW'(rest_q);
		sts.rest_gt1  = rest_q > W'(1);
		sts.div_done  = div_done;
		sts.rem_zero  = div_rem == '0;
		sts.exp_nz    = e_q != '0;
		sts.pend_v    = pend_v_q;
	end

	// Pending pair flag; the held pair waits until its last bit is known.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (cmd.load) begin
			pend_v_q <= 1'b0;
		end else if (cmd.div_miss && e_q != '0) begin
			pend_v_q <= 1'b1;
		end
	end

	// Remaining value, trial divisor, its square and the running exponent.
	// After two the divisor steps over the even numbers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q <= num_w;
			d_q    <= DW'(2);
			sq_q   <= SW'(4);
			e_q    <= '0;
		end else if (cmd.div_hit) begin
			rest_q <= div_quo;
			e_q    <= e_q + EXP_W'(1);
		end else if (cmd.div_miss) begin
			if (e_q != '0) begin
				pend_p_q <= d_q;
				pend_e_q <= e_q;
			end
			e_q <= '0;
			if (d_q == DW'(2)) begin
				d_q  <= DW'(3);
				sq_q <= SW'(9);
			end else begin
				d_q  <= d_q + DW'(2);
				sq_q <= sq_q + (SW'(d_q) << 2) + SW'(4);
			end
		end
	end

	// Result strobe, one beat per emit command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit != EMIT_NONE;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		unique case (cmd.emit)
			EMIT_MID: begin
				prime_q <= PRIME_W'(pend_p_q);
				exp_q   <= pend_e_q;
				last_q  <= 1'b0;
			end
			EMIT_LAST: begin
				prime_q <= PRIME_W'(pend_p_q);
				exp_q   <= pend_e_q;
				last_q  <= 1'b1;
			end
			EMIT_REST: begin
				prime_q <= PRIME_W'(rest_q);
				exp_q   <= EXP_W'(1);
				last_q  <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign strobe   = strobe_q;
	assign prime    = prime_q;
	assign exponent = exp_q;
	assign last     = last_q;

endmodule

@@ rtl/core/pf_ctrl.sv @@
module pf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pf_pkg::pf_sts_t sts,
	output pf_pkg::pf_cmd_t cmd,
	output logic            busy
);
	import pf_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_FINAL = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	// Next state and commands.
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && !sts.num_small) begin
					cmd.load = 1'b1;
					state_nx = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.sq_gt) begin
					if (!sts.rest_gt1) begin
						cmd.emit = EMIT_LAST;
						state_nx = ST_IDLE;
					end else if (sts.pend_v) begin
						cmd.emit = EMIT_MID;
						state_nx = ST_FINAL;
					end else begin
						cmd.emit = EMIT_REST;
						state_nx = ST_IDLE;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_nx      = ST_WAIT;
				end
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_nx      = ST_WAIT;
			end
			ST_WAIT: begin
				if (sts.div_done) begin
					if (sts.rem_zero) begin
						cmd.div_hit = 1'b1;
						state_nx    = ST_DIV;
					end else begin
						cmd.div_miss = 1'b1;
						if (sts.exp_nz && sts.pend_v) begin
							cmd.emit = EMIT_MID;
						end
						state_nx = ST_CHECK;
					end
				end
			end
			ST_FINAL: begin
				cmd.emit = EMIT_REST;
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = state_q != ST_IDLE;

endmodule
